// ----- rtl/shm_pkg.sv -----
// Package for the SHA-256 header midstate unit: widths, round constants,
// initial hash values, SHA-256 bit functions and the controller command type.
// No dependencies.
package shm_pkg;

    localparam int WORD_W    = 32;
    localparam int PART_W    = 64;
    localparam int NUM_PARTS = 10;
    localparam int NUM_OUT   = 6;
    localparam int IN_W      = PART_W * NUM_PARTS;
    localparam int OUT_W     = PART_W * NUM_OUT;
    localparam int ROUNDS    = 64;
    localparam int ROUND_W   = $clog2(ROUNDS);
    localparam int SCHED_LEN = 16;
    localparam int TAIL_W    = 2 * PART_W;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic               load;
        logic               step;
        logic               finish;
        logic [ROUND_W-1:0] round;
    } t_dp_cmd;

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ----- rtl/sha256_header_midstate_unit.sv -----
// SHA-256 header midstate unit: one 80-byte header in, midstate plus tail out.
// Sequence: the input transfer loads the schedule and working variables, then 64 rounds
// run on the single round unit, then one finish add writes the output register once it is free.
// A new header is taken only after the previous one has finished; the next transfer is
// taken while the previous result waits. Reset clears the controller and output valid only.
module sha256_header_midstate_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // header_part_0 .. header_part_9, 64 bits each, part 0 in bits 63:0
    input  logic [shm_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // state_ab, state_cd, state_ef, state_gh, tail_first, tail_second, 64 bits each
    output logic [shm_pkg::OUT_W-1:0] m_axis_tdata
);
    import shm_pkg::*;

    t_dp_cmd cmd;

    shm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    shm_datapath u_datapath (
        .i_clk  (i_clk),
        .i_cmd  (cmd),
        .i_data (s_axis_tdata),
        .o_data (m_axis_tdata)
    );

endmodule

// ----- rtl/shm_ctrl.sv -----
// Controller for the SHA-256 header midstate unit: sequences load, 64 rounds
// and finish, and owns the input ready and output valid handshake.
// Depends on shm_pkg.
module shm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output shm_pkg::t_dp_cmd o_cmd
);
    import shm_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ROUND  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

    logic [1:0]         r_state, n_state;
    logic [ROUND_W-1:0] r_round, n_round;
    logic               r_out_valid, n_out_valid;
    logic               in_xfer;
    logic               out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.round = r_round;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    o_cmd.load = 1'b1;
                    n_round    = '0;
                    n_state    = ST_ROUND;
                end
            end
            ST_ROUND: begin
                o_cmd.step = 1'b1;
                n_round    = r_round + 1'b1;
                if (r_round == LAST_ROUND) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold the result until the output register can take it
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    a_load_starts_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == ST_ROUND) && (r_round == '0))
        else $error("load did not start round zero");

    a_last_round_to_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) && (r_round == LAST_ROUND) |=> (r_state == ST_FINISH))
        else $error("last round did not lead to finish");

    a_finish_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid && (r_state == ST_IDLE))
        else $error("finish did not present a result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("finish overwrote a pending result");

endmodule

// ----- rtl/shm_datapath.sv -----
// Datapath for the SHA-256 header midstate unit: 16-word schedule window,
// working variables with one compression round per step, and output register.
// Depends on shm_pkg.
module shm_datapath (
    input  logic                      i_clk,
    input  shm_pkg::t_dp_cmd          i_cmd,
    input  logic [shm_pkg::IN_W-1:0]  i_data,
    output logic [shm_pkg::OUT_W-1:0] o_data
);
    import shm_pkg::*;

    t_word              r_w [SCHED_LEN];
    t_word              r_v [8];
    logic [TAIL_W-1:0]  r_tail;
    logic [OUT_W-1:0]   r_out;

    t_word w_next;
    t_word t1;
    t_word t2;
    t_word choose;
    t_word major;

    assign w_next = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
    assign choose = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign major  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1     = r_v[7] + big_sigma1(r_v[4]) + choose + K_TABLE[i_cmd.round] + r_w[0];
    assign t2     = big_sigma0(r_v[0]) + major;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int p = 0; p < SCHED_LEN / 2; p++) begin
                r_w[2*p]   <= i_data[PART_W*p + WORD_W +: WORD_W];
                r_w[2*p+1] <= i_data[PART_W*p +: WORD_W];
            end
            for (int j = 0; j < 8; j++) begin
                r_v[j] <= INIT_HASH[j];
            end
            r_tail <= i_data[IN_W-1 -: TAIL_W];
        end else if (i_cmd.step) begin
            // advance the schedule window by one word
            for (int j = 0; j < SCHED_LEN - 1; j++) begin
                r_w[j] <= r_w[j+1];
            end
            r_w[SCHED_LEN-1] <= w_next;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (i_cmd.finish) begin
            for (int q = 0; q < 4; q++) begin
                r_out[PART_W*q + WORD_W +: WORD_W] <= r_v[2*q] + INIT_HASH[2*q];
                r_out[PART_W*q +: WORD_W]          <= r_v[2*q+1] + INIT_HASH[2*q+1];
            end
            r_out[OUT_W-1 -: TAIL_W] <= r_tail;
        end
    end

    assign o_data = r_out;

endmodule
